// ===== hw/rtl/lbp_pkg.sv =====
// Shared types, codes and constants for the LED blink and breathing PWM block.
`timescale 1ns / 1ps
package lbp_pkg;

  // Command codes carried in the action field
  typedef enum logic [2:0] {
    ACT_TICK       = 3'd0,
    ACT_LED_ON     = 3'd1,
    ACT_LED_OFF    = 3'd2,
    ACT_LED_BLINK  = 3'd3,
    ACT_FADE_START = 3'd4,
    ACT_FADE_STOP  = 3'd5,
    ACT_SET_DUTY   = 3'd6
  } action_e;

  typedef enum logic [2:0] {
    ST_OK           = 3'd0,
    ST_BAD_LED      = 3'd1,
    ST_BAD_PERIOD   = 3'd2,
    ST_BAD_STEP     = 3'd3,
    ST_BAD_INTERVAL = 3'd4,
    ST_BAD_PWM      = 3'd5
  } status_e;

  typedef enum logic [1:0] {
    MODE_OFF   = 2'd0,
    MODE_ON    = 2'd1,
    MODE_BLINK = 2'd2
  } led_mode_e;

  localparam logic [15:0] PERIOD_MIN   = 16'd10;
  localparam logic [15:0] PERIOD_MAX   = 16'd60000;
  localparam logic [7:0]  STEP_MIN     = 8'd1;
  localparam logic [7:0]  STEP_MAX     = 8'd20;
  localparam logic [15:0] INTERVAL_MIN = 16'd10;
  localparam logic [15:0] INTERVAL_MAX = 16'd2000;
  localparam logic [7:0]  DUTY_MAX     = 8'd100;
  localparam logic [2:0]  PWM_CHANNEL  = 3'd1;
  localparam logic [8:0]  PCT_FULL     = 9'sd100;

  // ceil(2.55 * 2^16): exact floor(pct*255/100) for pct up to 100
  localparam logic [24:0] SCALE_MULT   = 25'd167117;

  typedef struct packed {
    logic        tick;
    logic        set_on;
    logic        set_off;
    logic        blink;
    logic [15:0] period;
  } led_cmd_t;

  typedef struct packed {
    logic        tick;
    logic        start;
    logic        stop;
    logic        set_duty;
    logic [4:0]  step;
    logic [10:0] interval;
    logic [6:0]  duty;
  } fade_cmd_t;

  typedef struct packed {
    logic [2:0]  action;
    logic [2:0]  led_id;
    logic [15:0] blink_period;
    logic [7:0]  fade_step;
    logic [15:0] fade_interval;
    logic [2:0]  pwm_id;
    logic [7:0]  duty_percent;
  } in_word_t;

  // Percent (0..100) to PWM compare value, truncated
  function automatic logic [7:0] scale_duty(input logic [6:0] pct);
    logic [24:0] prod;
    prod = 25'(pct) * SCALE_MULT;
    return prod[23:16];
  endfunction

endpackage

// ===== hw/rtl/lbp_if.sv =====
// Handshake channels for command words and result words.
`timescale 1ns / 1ps
interface lbp_in_if;
  logic        valid;
  logic        ready;
  logic [2:0]  action;
  logic [2:0]  led_id;
  logic [15:0] blink_period;
  logic [7:0]  fade_step;
  logic [15:0] fade_interval;
  logic [2:0]  pwm_id;
  logic [7:0]  duty_percent;

  modport source (output valid, action, led_id, blink_period, fade_step, fade_interval,
                  pwm_id, duty_percent, input ready);
  modport sink (input valid, action, led_id, blink_period, fade_step, fade_interval,
                pwm_id, duty_percent, output ready);
endinterface

interface lbp_out_if;
  logic       valid;
  logic       ready;
  logic [2:0] led_levels;
  logic [7:0] pwm_level;
  logic       fade_running;
  logic [2:0] status;

  modport source (output valid, led_levels, pwm_level, fade_running, status, input ready);
  modport sink (input valid, led_levels, pwm_level, fade_running, status, output ready);
endinterface

// ===== hw/rtl/led_blink_and_breathing_pwm.sv =====
// LED blink and breathing PWM controller: one command or tick per clock unless
// the result is held back by out_o.ready. A word goes from the input register to
// the state update with result capture. Throughput: one word per cycle, under the
// same out_o.ready condition.
// Reset (asynchronous, active low): LEDs off, fade stopped and rising,
// PWM compare value 0, both pipeline stages empty.
`timescale 1ns / 1ps
module led_blink_and_breathing_pwm #(
  parameter int NUM_LEDS = 3
) (
  input  logic clk_i,
  input  logic rst_ni,
  lbp_in_if.sink    in_i,
  lbp_out_if.source out_o
);
  import lbp_pkg::*;

  logic      in_valid_q;
  in_word_t  in_q;
  logic      out_valid_q;
  status_e   status_q, status_d;
  logic      advance, process;
  action_e   act;
  logic      id_ok, period_ok, step_ok, interval_ok, duty_ok;
  logic      do_on, do_off, do_blink;
  logic [NUM_LEDS-1:0] led_hit;
  logic [NUM_LEDS-1:0] levels;
  led_cmd_t  led_cmd [NUM_LEDS];
  fade_cmd_t fade_cmd;
  logic [7:0] pwm_level;
  logic      fade_on;

  assign advance    = !out_valid_q || out_o.ready;
  assign process    = in_valid_q && advance;
  assign in_i.ready = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      in_valid_q <= in_i.valid;
    end
  end

  // payload register: load on accept only
  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      in_q <= '{action:        in_i.action,
                led_id:        in_i.led_id,
                blink_period:  in_i.blink_period,
                fade_step:     in_i.fade_step,
                fade_interval: in_i.fade_interval,
                pwm_id:        in_i.pwm_id,
                duty_percent:  in_i.duty_percent};
    end
  end

  assign act         = action_e'(in_q.action);
  assign id_ok       = (in_q.led_id != 3'd0) && ({1'b0, in_q.led_id} <= 4'(NUM_LEDS));
  assign period_ok   = (in_q.blink_period >= PERIOD_MIN) && (in_q.blink_period <= PERIOD_MAX);
  assign step_ok     = (in_q.fade_step >= STEP_MIN) && (in_q.fade_step <= STEP_MAX);
  assign interval_ok = (in_q.fade_interval >= INTERVAL_MIN)
                    && (in_q.fade_interval <= INTERVAL_MAX);
  assign duty_ok     = (in_q.pwm_id == PWM_CHANNEL) && (in_q.duty_percent <= DUTY_MAX);

  always_comb begin
    status_d = ST_OK;
    do_on    = 1'b0;
    do_off   = 1'b0;
    do_blink = 1'b0;
    fade_cmd = '0;
    fade_cmd.step     = in_q.fade_step[4:0];
    fade_cmd.interval = in_q.fade_interval[10:0];
    fade_cmd.duty     = in_q.duty_percent[6:0];
    unique case (act)
      ACT_TICK: begin
        fade_cmd.tick = process;
      end
      ACT_LED_ON, ACT_LED_OFF: begin
        if (!id_ok) begin
          status_d = ST_BAD_LED;
        end else begin
          do_on  = process && (act == ACT_LED_ON);
          do_off = process && (act == ACT_LED_OFF);
        end
      end
      ACT_LED_BLINK: begin
        priority if (!id_ok) begin
          status_d = ST_BAD_LED;
        end else if (!period_ok) begin
          status_d = ST_BAD_PERIOD;
        end else begin
          do_blink = process;
        end
      end
      ACT_FADE_START: begin
        priority if (!step_ok) begin
          status_d = ST_BAD_STEP;
        end else if (!interval_ok) begin
          status_d = ST_BAD_INTERVAL;
        end else begin
          fade_cmd.start = process;
        end
      end
      ACT_FADE_STOP: begin
        fade_cmd.stop = process;
      end
      ACT_SET_DUTY: begin
        if (!duty_ok) begin
          status_d = ST_BAD_PWM;
        end else begin
          fade_cmd.set_duty = process;
        end
      end
      default: begin
        // unknown action: no change
      end
    endcase
  end

  for (genvar g = 0; g < NUM_LEDS; g++) begin : g_led
    assign led_hit[g] = ({1'b0, in_q.led_id} == 4'(g + 1));
    always_comb begin
      led_cmd[g].tick    = process && (act == ACT_TICK);
      led_cmd[g].set_on  = do_on && led_hit[g];
      led_cmd[g].set_off = do_off && led_hit[g];
      led_cmd[g].blink   = do_blink && led_hit[g];
      led_cmd[g].period  = in_q.blink_period;
    end
    lbp_led_chan u_led (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .cmd_i   (led_cmd[g]),
      .level_o (levels[g])
    );
  end

  lbp_fade u_fade (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (fade_cmd),
    .pwm_level_o (pwm_level),
    .fade_on_o   (fade_on)
  );

  // state registers hold the post-word state while the result waits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      status_q    <= ST_OK;
    end else if (process) begin
      out_valid_q <= 1'b1;
      status_q    <= status_d;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  for (genvar b = 0; b < 3; b++) begin : g_lvl
    if (b < NUM_LEDS) begin : g_used
      assign out_o.led_levels[b] = levels[b];
    end else begin : g_pad
      assign out_o.led_levels[b] = 1'b0;
    end
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.pwm_level    = pwm_level;
  assign out_o.fade_running = fade_on;
  assign out_o.status       = status_q;
endmodule

// ===== hw/rtl/lbp_led_chan.sv =====
// One LED channel: on/off/blink mode, level and blink down-counter.
`timescale 1ns / 1ps
module lbp_led_chan (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  lbp_pkg::led_cmd_t cmd_i,
  output logic              level_o
);
  import lbp_pkg::*;

  led_mode_e   mode_q, mode_d;
  logic        level_q, level_d;
  logic [15:0] period_q, period_d;
  logic [15:0] remain_q, remain_d;
  logic [15:0] remain_dec;

  assign remain_dec = (remain_q == '0) ? '0 : remain_q - 16'd1;

  always_comb begin
    mode_d   = mode_q;
    level_d  = level_q;
    period_d = period_q;
    remain_d = remain_q;
    priority if (cmd_i.set_on) begin
      mode_d  = MODE_ON;
      level_d = 1'b1;
    end else if (cmd_i.set_off) begin
      mode_d  = MODE_OFF;
      level_d = 1'b0;
    end else if (cmd_i.blink) begin
      mode_d   = MODE_BLINK;
      period_d = cmd_i.period;
      remain_d = cmd_i.period;
    end else if (cmd_i.tick && mode_q == MODE_BLINK) begin
      // count down; on expiry toggle and reload
      if (remain_dec == '0) begin
        level_d  = ~level_q;
        remain_d = period_q;
      end else begin
        remain_d = remain_dec;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= MODE_OFF;
      level_q  <= 1'b0;
      period_q <= '0;
      remain_q <= '0;
    end else begin
      mode_q   <= mode_d;
      level_q  <= level_d;
      period_q <= period_d;
      remain_q <= remain_d;
    end
  end

  assign level_o = level_q;
endmodule

// ===== hw/rtl/lbp_fade.sv =====
// Breathing fade ramp and PWM compare register.
`timescale 1ns / 1ps
module lbp_fade (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  lbp_pkg::fade_cmd_t cmd_i,
  output logic [7:0]         pwm_level_o,
  output logic               fade_on_o
);
  import lbp_pkg::*;

  logic        on_q, on_d;
  logic        rising_q, rising_d;
  logic [4:0]  incr_q, incr_d;
  logic [10:0] period_q, period_d;
  logic [10:0] remain_q, remain_d;
  logic [6:0]  pct_q, pct_d;
  logic [7:0]  pwm_q, pwm_d;
  logic [10:0] remain_dec;
  logic signed [8:0] pct_next;
  logic [6:0]  pct_clamped;
  logic        hit_top, hit_bottom;
  logic [6:0]  scale_pct;
  logic [7:0]  scaled;

  assign remain_dec = (remain_q == '0) ? '0 : remain_q - 11'd1;
  assign pct_next   = rising_q ? $signed({2'b00, pct_q}) + $signed({4'b0000, incr_q})
                               : $signed({2'b00, pct_q}) - $signed({4'b0000, incr_q});
  assign hit_top    = pct_next >= $signed(PCT_FULL);
  assign hit_bottom = pct_next <= 9'sd0;
  assign pct_clamped = hit_top ? 7'd100 : (hit_bottom ? 7'd0 : pct_next[6:0]);

  // one scaler shared by fixed duty and fade steps
  assign scale_pct = cmd_i.set_duty ? cmd_i.duty : pct_clamped;
  assign scaled    = scale_duty(scale_pct);

  always_comb begin
    on_d     = on_q;
    rising_d = rising_q;
    incr_d   = incr_q;
    period_d = period_q;
    remain_d = remain_q;
    pct_d    = pct_q;
    pwm_d    = pwm_q;
    priority if (cmd_i.start) begin
      incr_d   = cmd_i.step;
      period_d = cmd_i.interval;
      remain_d = cmd_i.interval;
      rising_d = 1'b1;
      pct_d    = '0;
      on_d     = 1'b1;
    end else if (cmd_i.stop) begin
      on_d  = 1'b0;
      pwm_d = '0;
    end else if (cmd_i.set_duty) begin
      on_d  = 1'b0;
      pwm_d = scaled;
    end else if (cmd_i.tick && on_q) begin
      if (remain_dec == '0) begin
        remain_d = period_q;
        pct_d    = pct_clamped;
        pwm_d    = scaled;
        if (hit_top) begin
          rising_d = 1'b0;
        end else if (hit_bottom) begin
          rising_d = 1'b1;
        end
      end else begin
        remain_d = remain_dec;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      on_q     <= 1'b0;
      rising_q <= 1'b1;
      incr_q   <= '0;
      period_q <= '0;
      remain_q <= '0;
      pct_q    <= '0;
      pwm_q    <= '0;
    end else begin
      on_q     <= on_d;
      rising_q <= rising_d;
      incr_q   <= incr_d;
      period_q <= period_d;
      remain_q <= remain_d;
      pct_q    <= pct_d;
      pwm_q    <= pwm_d;
    end
  end

  assign pwm_level_o = pwm_q;
  assign fade_on_o   = on_q;
endmodule
